FILE: rtl/core/complex_polar_cartesian_unit_core_macros.svh
// Assertion macros shared by the complex polar/cartesian unit RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the user.
`ifndef COMPLEX_POLAR_CARTESIAN_UNIT_CORE_MACROS_SVH
`define COMPLEX_POLAR_CARTESIAN_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPCU_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cpcu_pkg.sv
// Shared constants, types and functions of the complex polar/cartesian unit.
// No dependencies; imported by cpcu_cordic and the top level.
package cpcu_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_BITS    = 16;

  // Data path and angle accumulator widths.
  localparam int DW = 52;
  localparam int ZW = 36;

  localparam logic [32:0] PI_Q30      = 33'd3373259424;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629712;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518848;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;

  // Angle scaling from the input format to Q.30.
  localparam int ZSH = 30 - FRACTION_BITS;

  // Reciprocal of 2*pi for the angle range reduction.
  localparam logic [127:0] RECIP_WIDE = (128'd1 << 64) / 128'd6746518848;
  localparam logic [31:0]  RECIP      = RECIP_WIDE[31:0];
  localparam int           QSH        = 64 - ZSH;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    OP_CART  = 2'd0,
    OP_POLAR = 2'd1,
    OP_ADD   = 2'd2,
    OP_PASS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first_form;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic vec;
    logic byp;
  } ctl_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'h3243F6A8;  1: r = 32'h1DAC6705;  2: r = 32'h0FADBAFC;
      3: r = 32'h07F56EA6;  4: r = 32'h03FEAB76;  5: r = 32'h01FFD55B;
      6: r = 32'h00FFFAAA;  7: r = 32'h007FFF55;  8: r = 32'h003FFFEA;
      9: r = 32'h001FFFFD; 10: r = 32'h000FFFFF; 11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF; 13: r = 32'h0001FFFF; 14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF; 16: r = 32'h00003FFF; 17: r = 32'h00001FFF;
      18: r = 32'h00000FFF; 19: r = 32'h000007FF; 20: r = 32'h000003FF;
      21: r = 32'h000001FF; 22: r = 32'h000000FF; 23: r = 32'h0000007F;
      24: r = 32'h0000003F; 25: r = 32'h0000001F; 26: r = 32'h0000000F;
      27: r = 32'h00000008; 28: r = 32'h00000004; 29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cpcu_cordic.sv
// Pipelined CORDIC lane: angle reduction, rotation or vectoring, gain and rounding.
// Depends on cpcu_pkg and complex_polar_cartesian_unit_core_macros.svh.
`include "complex_polar_cartesian_unit_core_macros.svh"
module cpcu_cordic
  import cpcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  ctl_t               in_ctl,
  input  logic signed [31:0] in_p,
  input  logic signed [31:0] in_q,
  output logic               out_valid,
  output ctl_t               out_ctl,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im
);

  localparam int GW = 62 - (30 - GUARD_BITS);
  localparam int TW = 32 + ZSH;
  localparam int PW = ZSH + 33;
  localparam int HW = DW - 30;
  localparam logic signed [ZW-1:0] PI_Z      = $signed({{(ZW-33){1'b0}}, PI_Q30});
  localparam logic signed [ZW-1:0] HALF_PI_Z = $signed({{(ZW-33){1'b0}}, HALF_PI_Q30});
  localparam logic signed [ZW-1:0] TWO_PI_Z  = $signed({{(ZW-33){1'b0}}, TWO_PI_Q30});
  localparam int ANG_LIM = int'((64'(PI_Q30) + (64'd1 << (ZSH - 1))) >> ZSH);

  // Stage 1: magnitudes and the two products.
  logic               v1_r;
  ctl_t               c1_r;
  logic signed [31:0] p1_r, q1_r;
  logic [31:0]        tabs1_r;
  logic [63:0]        qprod1_r;
  logic [61:0]        gprod1_r;
  logic               tneg1_r, rneg1_r;
  logic [31:0]        tabs, rabs;

  always_comb begin
    tabs = in_q[31] ? 32'(-in_q) : 32'(in_q);
    rabs = in_p[31] ? 32'(-in_p) : 32'(in_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_r     <= in_ctl;
      p1_r     <= in_p;
      q1_r     <= in_q;
      tabs1_r  <= tabs;
      tneg1_r  <= in_q[31];
      rneg1_r  <= in_p[31];
      qprod1_r <= 64'(tabs) * 64'(RECIP);
      gprod1_r <= 62'(rabs) * 62'(GAIN_Q30);
    end
  end

  // Stage 2: remainder estimate and scaled rotation magnitude.
  logic               v2_r;
  ctl_t               c2_r;
  logic signed [31:0] p2_r, q2_r;
  logic [33:0]        rem2_r;
  logic               tneg2_r;
  logic signed [DW-1:0] xrot2_r;
  logic [PW-1:0]      qp, remf;
  logic [TW-1:0]      tz;
  logic signed [DW-1:0] xs;

  always_comb begin
    tz   = {tabs1_r, {ZSH{1'b0}}};
    qp   = PW'(qprod1_r[63:QSH]) * PW'(TWO_PI_Q30);
    remf = PW'(tz) - qp;
    xs   = $signed({{(DW-GW){1'b0}}, gprod1_r[61:30-GUARD_BITS]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ce) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c2_r    <= c1_r;
      p2_r    <= p1_r;
      q2_r    <= q1_r;
      rem2_r  <= remf[33:0];
      tneg2_r <= tneg1_r;
      xrot2_r <= rneg1_r ? -xs : xs;
    end
  end

  // Stage 3: final remainder correction with the sign of the dividend.
  logic               v3_r;
  ctl_t               c3_r;
  logic signed [31:0] p3_r, q3_r;
  logic signed [ZW-1:0] zs3_r;
  logic signed [DW-1:0] xrot3_r;
  logic [33:0]        remc;
  logic signed [ZW-1:0] zmag;

  always_comb begin
    remc = (rem2_r >= 34'(TWO_PI_Q30)) ? rem2_r - 34'(TWO_PI_Q30) : rem2_r;
    zmag = $signed({{(ZW-34){1'b0}}, remc});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ce) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c3_r    <= c2_r;
      p3_r    <= p2_r;
      q3_r    <= q2_r;
      zs3_r   <= tneg2_r ? -zmag : zmag;
      xrot3_r <= xrot2_r;
    end
  end

  // CORDIC stages; index 0 holds the initial vector.
  logic                 vld_r  [0:CORDIC_STEPS];
  ctl_t                 ctl_r  [0:CORDIC_STEPS];
  logic signed [31:0]   p_r    [0:CORDIC_STEPS];
  logic signed [31:0]   q_r    [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];
  logic signed [DW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [DW-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STEPS];

  logic signed [DW-1:0] x0_nxt, y0_nxt, xv, yv, xr;
  logic signed [ZW-1:0] z0_nxt, zv, zr;

  always_comb begin
    // Rotation: fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip.
    zr = zs3_r;
    xr = xrot3_r;
    if (zr > PI_Z) begin
      zr = zr - TWO_PI_Z;
    end else if (zr < -PI_Z) begin
      zr = zr + TWO_PI_Z;
    end
    if (zr > HALF_PI_Z) begin
      zr = zr - PI_Z;
      xr = -xr;
    end else if (zr < -HALF_PI_Z) begin
      zr = zr + PI_Z;
      xr = -xr;
    end
    // Vectoring: move a left-half vector to the right half and start at +/-pi.
    xv = DW'(p3_r) <<< GUARD_BITS;
    yv = DW'(q3_r) <<< GUARD_BITS;
    zv = '0;
    if (xv < 0) begin
      zv = (yv >= 0) ? PI_Z : -PI_Z;
      xv = -xv;
      yv = -yv;
    end
    if (c3_r.vec) begin
      x0_nxt = xv;
      y0_nxt = yv;
      z0_nxt = zv;
    end else begin
      x0_nxt = xr;
      y0_nxt = '0;
      z0_nxt = zr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctl_r[0]  <= c3_r;
      p_r[0]    <= p3_r;
      q_r[0]    <= q3_r;
      zero_r[0] <= (p3_r == 32'sd0) && (q3_r == 32'sd0);
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
    end
  end

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
    logic signed [DW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 pos;

    // The x update uses the shifted y and the y update the shifted x.
    always_comb begin
      dx  = y_r[gi] >>> gi;
      dy  = x_r[gi] >>> gi;
      at  = $signed({{(ZW-32){1'b0}}, atan_q30(gi)});
      pos = ctl_r[gi].vec ? y_r[gi][DW-1] : !z_r[gi][ZW-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gi+1] <= 1'b0;
      end else if (ce) begin
        vld_r[gi+1] <= vld_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ctl_r[gi+1]  <= ctl_r[gi];
        p_r[gi+1]    <= p_r[gi];
        q_r[gi+1]    <= q_r[gi];
        zero_r[gi+1] <= zero_r[gi];
        x_r[gi+1]    <= pos ? x_r[gi] - dx : x_r[gi] + dx;
        y_r[gi+1]    <= pos ? y_r[gi] + dy : y_r[gi] - dy;
        z_r[gi+1]    <= pos ? z_r[gi] - at : z_r[gi] + at;
      end
    end
  end

  // Post stage A: angle clamp and the split gain products.
  logic                 va_r;
  ctl_t                 ca_r;
  logic signed [31:0]   pa_r, qa_r;
  logic signed [DW-1:0] xa_r, ya_r;
  logic signed [ZW-1:0] za_r;
  logic [HW+29:0]       ppa_r;
  logic [59:0]          ppb_r;
  logic signed [ZW-1:0] zc;
  logic signed [DW-1:0] xn;

  always_comb begin
    xn = x_r[CORDIC_STEPS];
    zc = z_r[CORDIC_STEPS];
    if (zc > PI_Z) begin
      zc = PI_Z;
    end else if (zc < -PI_Z) begin
      zc = -PI_Z;
    end
    if (zero_r[CORDIC_STEPS]) begin
      zc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ce) begin
      va_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ca_r  <= ctl_r[CORDIC_STEPS];
      pa_r  <= p_r[CORDIC_STEPS];
      qa_r  <= q_r[CORDIC_STEPS];
      xa_r  <= xn;
      ya_r  <= y_r[CORDIC_STEPS];
      za_r  <= zc;
      ppa_r <= (HW+30)'(xn[DW-1:30]) * (HW+30)'(GAIN_Q30);
      ppb_r <= 60'(xn[29:0]) * 60'(GAIN_Q30);
    end
  end

  // Post stage B: rounding, saturation and result selection.
  logic               vb_r;
  ctl_t               cb_r;
  logic signed [31:0] re_r, im_r;
  logic signed [63:0] rho, rnd_g, rnd_z;
  logic signed [31:0] re_nxt, im_nxt;

  always_comb begin
    rnd_g = 64'sd1 <<< (GUARD_BITS - 1);
    rnd_z = 64'sd1 <<< (ZSH - 1);
    rho   = $signed(64'(ppa_r) + 64'(ppb_r[59:30]));
    if (ca_r.byp) begin
      re_nxt = pa_r;
      im_nxt = qa_r;
    end else if (ca_r.vec) begin
      re_nxt = sat32((rho + rnd_g) >>> GUARD_BITS);
      im_nxt = sat32((64'(za_r) + rnd_z) >>> ZSH);
    end else begin
      re_nxt = sat32((64'(xa_r) + rnd_g) >>> GUARD_BITS);
      im_nxt = sat32((64'(ya_r) + rnd_g) >>> GUARD_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ce) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cb_r <= ca_r;
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_ctl   = cb_r;
  assign out_re    = re_r;
  assign out_im    = im_r;

  `CPCU_ASSERT(a_vec_rho_pos, vb_r && cb_r.vec && !cb_r.byp, re_r >= 0,
    "vectoring magnitude is negative")
  `CPCU_ASSERT(a_vec_angle, vb_r && cb_r.vec && !cb_r.byp,
    (im_r <= ANG_LIM) && (im_r >= -ANG_LIM), "vectoring angle beyond pi")
  `CPCU_ASSERT_NEXT(a_hold, va_r && !ce, va_r && $stable(xa_r) && $stable(za_r),
    "pipeline stage changed while stalled")

endmodule

FILE: rtl/core/complex_polar_cartesian_unit_core.sv
// Top level of the complex polar/cartesian conversion and addition unit.
// Depends on cpcu_pkg, cpcu_cordic and complex_polar_cartesian_unit_core_macros.svh.
//
// Usage
// -----
// Each input beat carries an opcode and two complex values, each tagged cartesian
// or polar in signed Q16.16. One result beat leaves for every input beat, in order.
// Opcode 0 gives the first value in cartesian form, opcode 1 in polar form, opcode
// 2 the cartesian sum of both values, and opcode 3 passes the first value through.
// Two CORDIC lanes run side by side: the first serves the first value in rotation or
// vectoring mode, the second rotates the second value for the addition.
// Stages in order: angle range reduction, one initial vector stage, one stage per
// CORDIC step, two stages of gain, rounding and saturation, and the output register
// that forms the sum. Throughput is one beat per cycle while the receiver does not
// stall; every stage is one register of the pipeline.
// The whole pipeline advances together whenever the output register is empty or
// its beat is being taken, so a stalled receiver holds every stage in place and
// in_ready falls in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; no clearing pass is needed and the unit accepts a
// beat in the first cycle after reset.
`include "complex_polar_cartesian_unit_core_macros.svh"
module complex_polar_cartesian_unit_core
  import cpcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic               in_first_form,
  input  logic signed [31:0] in_first_real_or_rho,
  input  logic signed [31:0] in_first_imag_or_angle,
  input  logic               in_second_form,
  input  logic signed [31:0] in_second_real_or_rho,
  input  logic signed [31:0] in_second_imag_or_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_form,
  output logic signed [31:0] out_result_real_or_rho,
  output logic signed [31:0] out_result_imag_or_angle
);

  logic               ce;
  op_t                op;
  ctl_t               a_ctl_in, b_ctl_in, a_ctl, b_ctl;
  logic               a_valid, b_valid;
  logic signed [31:0] a_re, a_im, b_re, b_im;

  logic               out_valid_r;
  logic               form_r, form_nxt;
  logic signed [31:0] re_r, im_r, re_nxt, im_nxt;

  // The pipeline moves when the output register can take a new beat.
  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;
  assign op       = op_t'(in_opcode);

  // The first lane converts the first value only when its form differs from the
  // target; otherwise it carries the value through untouched.
  always_comb begin
    a_ctl_in.tag.op         = op;
    a_ctl_in.tag.first_form = in_first_form;
    a_ctl_in.vec            = (op == OP_POLAR);
    case (op)
      OP_CART, OP_ADD: a_ctl_in.byp = !in_first_form;
      OP_POLAR:        a_ctl_in.byp = in_first_form;
      default:         a_ctl_in.byp = 1'b1;
    endcase
    b_ctl_in.tag = a_ctl_in.tag;
    b_ctl_in.vec = 1'b0;
    b_ctl_in.byp = !in_second_form;
  end

  cpcu_cordic u_lane_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_valid),
    .in_ctl    (a_ctl_in),
    .in_p      (in_first_real_or_rho),
    .in_q      (in_first_imag_or_angle),
    .out_valid (a_valid),
    .out_ctl   (a_ctl),
    .out_re    (a_re),
    .out_im    (a_im)
  );

  cpcu_cordic u_lane_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_valid),
    .in_ctl    (b_ctl_in),
    .in_p      (in_second_real_or_rho),
    .in_q      (in_second_imag_or_angle),
    .out_valid (b_valid),
    .out_ctl   (b_ctl),
    .out_re    (b_re),
    .out_im    (b_im)
  );

  // Result selection; the addition saturates once more after the lane rounding.
  always_comb begin
    case (a_ctl.tag.op)
      OP_CART: begin
        form_nxt = 1'b0;
        re_nxt   = a_re;
        im_nxt   = a_im;
      end
      OP_POLAR: begin
        form_nxt = 1'b1;
        re_nxt   = a_re;
        im_nxt   = a_im;
      end
      OP_ADD: begin
        form_nxt = 1'b0;
        re_nxt   = sat32(64'(a_re) + 64'(b_re));
        im_nxt   = sat32(64'(a_im) + 64'(b_im));
      end
      default: begin
        form_nxt = a_ctl.tag.first_form;
        re_nxt   = a_re;
        im_nxt   = a_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      form_r <= form_nxt;
      re_r   <= re_nxt;
      im_r   <= im_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_result_form          = form_r;
  assign out_result_real_or_rho   = re_r;
  assign out_result_imag_or_angle = im_r;

  `CPCU_ASSERT(a_lane_valid, 1'b1, a_valid == b_valid, "lanes out of step")
  `CPCU_ASSERT(a_lane_tag, a_valid, a_ctl.tag == b_ctl.tag, "lane tags differ")
  `CPCU_ASSERT_NEXT(a_lane_hold, a_valid && !ce, a_valid && $stable(a_re) && $stable(b_re),
    "lane result lost while the output stalls")

endmodule

FILE: tb/tb_complex_polar_cartesian_unit_core.sv
// Self-checking bench for complex_polar_cartesian_unit_core: random and directed beats,
// a bit-exact fixed-point CORDIC predictor, and an in-order result scoreboard.
// Depends on cpcu_pkg and the RTL of the unit.
module tb_complex_polar_cartesian_unit_core;
  import cpcu_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic               f1;
    logic signed [31:0] p1;
    logic signed [31:0] q1;
    logic               f2;
    logic signed [31:0] p2;
    logic signed [31:0] q2;
  } beat_t;

  typedef struct {
    logic               form;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } conv_t;

  localparam longint GAIN    = 64'd652032874;
  localparam longint PI_V    = 64'd3373259424;
  localparam longint HPI_V   = 64'd1686629712;
  localparam longint TWOPI_V = 64'd6746518848;
  localparam int     TIMEOUT_CYCLES = 4000;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic [1:0]         in_opcode;
  logic               in_first_form, in_second_form;
  logic signed [31:0] in_first_real_or_rho, in_first_imag_or_angle;
  logic signed [31:0] in_second_real_or_rho, in_second_imag_or_angle;
  logic               out_valid, out_ready;
  logic               out_result_form;
  logic signed [31:0] out_result_real_or_rho, out_result_imag_or_angle;

  beat_t pending_beats[$];
  conv_t expected_results[$];
  int    send_idle_pct, recv_stall_pct;
  bit    hold_sender;
  int    errors, quiet_cycles, beats_in, beats_out;
  bit    stimulus_done;

  complex_polar_cartesian_unit_core uut (.*);

  // Arithmetic shift that never depends on the simulator's sign handling.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Gain scaling truncates the magnitude toward zero.
  function automatic longint scale_gain(longint v);
    longint m, r;
    m = (v < 0) ? -v : v;
    r = (m >>> 30) * GAIN + (((m & 64'h3FFFFFFF) * GAIN) >>> 30);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint round_out(longint v);
    return clamp32(shr(v + (64'sd1 <<< 15), 16));
  endfunction

  function automatic longint arctan(int i);
    return longint'(atan_q30(i));
  endfunction

  // Rotation-mode CORDIC: polar (rho, theta) to cartesian.
  function automatic void rotate(longint rho, longint theta, output longint a, output longint b);
    longint x, y, z, dx, dy;
    y = 0;
    z = (theta <<< 14) % TWOPI_V;
    if (z > PI_V) z -= TWOPI_V;
    if (z < -PI_V) z += TWOPI_V;
    x = scale_gain(rho <<< 16);
    if (z > HPI_V) begin
      z -= PI_V; x = -x;
    end else if (z < -HPI_V) begin
      z += PI_V; x = -x;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan(i);
      end else begin
        x += dx; y -= dy; z += arctan(i);
      end
    end
    a = round_out(x);
    b = round_out(y);
  endfunction

  // Vectoring-mode CORDIC: cartesian to magnitude and full-quadrant angle.
  function automatic void vector(longint a, longint b, output longint r, output longint t);
    longint x, y, z, dx, dy;
    x = a <<< 16;
    y = b <<< 16;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_V : -PI_V;
      x = -x; y = -y;
    end
    if (x != 0 || y != 0) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = shr(y, i);
        dy = shr(x, i);
        if (y < 0) begin
          x -= dx; y += dy; z -= arctan(i);
        end else begin
          x += dx; y -= dy; z += arctan(i);
        end
      end
    end
    if (z > PI_V) z = PI_V;
    if (z < -PI_V) z = -PI_V;
    r = round_out(scale_gain(x));
    t = clamp32(shr(z + (64'sd1 <<< 13), 14));
  endfunction

  function automatic void cartesian_of(logic f, longint p, longint q, output longint a,
                                       output longint b);
    if (f) rotate(p, q, a, b);
    else begin
      a = p; b = q;
    end
  endfunction

  function automatic conv_t predict_conversion(beat_t bt);
    conv_t  c;
    longint r0, r1, a1, b1, a2, b2;
    case (op_t'(bt.op))
      OP_CART: begin
        c.form = 1'b0;
        cartesian_of(bt.f1, bt.p1, bt.q1, r0, r1);
      end
      OP_POLAR: begin
        c.form = 1'b1;
        if (bt.f1) begin
          r0 = bt.p1; r1 = bt.q1;
        end else vector(bt.p1, bt.q1, r0, r1);
      end
      OP_ADD: begin
        c.form = 1'b0;
        cartesian_of(bt.f1, bt.p1, bt.q1, a1, b1);
        cartesian_of(bt.f2, bt.p2, bt.q2, a2, b2);
        r0 = clamp32(a1 + a2);
        r1 = clamp32(b1 + b2);
      end
      default: begin
        c.form = bt.f1;
        r0 = bt.p1; r1 = bt.q1;
      end
    endcase
    c.re = r0[31:0];
    c.im = r1[31:0];
    return c;
  endfunction

  // Mostly moderate magnitudes and in-range angles, with full-range values mixed in.
  function automatic logic signed [31:0] pick_value(bit is_angle);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      3:       return $signed($urandom_range(0, 65536)) - 32768;
      default: return is_angle ? $signed($urandom_range(0, 411774)) - 205887
                               : $signed($urandom_range(0, 2 ** 26)) - 2 ** 25;
    endcase
  endfunction

  task automatic queue_beat(logic [1:0] op, logic f1, logic signed [31:0] p1,
                            logic signed [31:0] q1, logic f2, logic signed [31:0] p2,
                            logic signed [31:0] q2);
    beat_t bt;
    bt.op = op; bt.f1 = f1; bt.p1 = p1; bt.q1 = q1;
    bt.f2 = f2; bt.p2 = p2; bt.q2 = q2;
    pending_beats.push_back(bt);
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      queue_beat($urandom_range(0, 3), $urandom_range(0, 1), pick_value(0), pick_value(1),
                 $urandom_range(0, 1), pick_value(0), pick_value(1));
    end
  endtask

  task automatic drain_pending();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: the valid holds its beat until the handshake, idles at random otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() != 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        beat_t bt;
        bt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_opcode <= bt.op;
        in_first_form <= bt.f1;
        in_first_real_or_rho <= bt.p1;
        in_first_imag_or_angle <= bt.q1;
        in_second_form <= bt.f2;
        in_second_real_or_rho <= bt.p2;
        in_second_imag_or_angle <= bt.q2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted input beat and checks each accepted result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        beat_t bt;
        bt.op = in_opcode; bt.f1 = in_first_form;
        bt.p1 = in_first_real_or_rho; bt.q1 = in_first_imag_or_angle;
        bt.f2 = in_second_form;
        bt.p2 = in_second_real_or_rho; bt.q2 = in_second_imag_or_angle;
        expected_results.push_back(predict_conversion(bt));
        beats_in++;
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat form=%0d re=%0d im=%0d", $time,
                   out_result_form, out_result_real_or_rho, out_result_imag_or_angle);
        end else begin
          conv_t c;
          c = expected_results.pop_front();
          if (c.form !== out_result_form) begin
            errors++;
            $display("%0t: form expected %0d actual %0d", $time, c.form, out_result_form);
          end
          if (c.re !== out_result_real_or_rho) begin
            errors++;
            $display("%0t: real/rho expected %0d actual %0d", $time, c.re,
                     out_result_real_or_rho);
          end
          if (c.im !== out_result_imag_or_angle) begin
            errors++;
            $display("%0t: imag/angle expected %0d actual %0d", $time, c.im,
                     out_result_imag_or_angle);
          end
        end
      end
    end
  end

  // Receiver back-pressure and the watchdog on cycles without any handshake.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (stimulus_done && expected_results.size() == 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= TIMEOUT_CYCLES) begin
        $display("complex_polar_cartesian_unit_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_opcode = '0;
    in_first_form = 1'b0;
    in_first_real_or_rho = '0;
    in_first_imag_or_angle = '0;
    in_second_form = 1'b0;
    in_second_real_or_rho = '0;
    in_second_imag_or_angle = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_sender = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    beats_in = 0;
    beats_out = 0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: every opcode, the zero vector, vectors in the first three quadrants
    // and on the negative real axis, angles past a quarter turn and far outside plus or
    // minus pi, negative magnitude, and sums that saturate in both directions.
    queue_beat(OP_CART, 1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 0, 0);
    queue_beat(OP_CART, 1'b1, 32'sh00010000, 32'sh0001921F, 1'b0, 0, 0);
    queue_beat(OP_CART, 1'b1, 32'sh00020000, 32'sh00030000, 1'b0, 0, 0);
    queue_beat(OP_CART, 1'b1, -32'sh00020000, -32'sh00028000, 1'b0, 0, 0);
    queue_beat(OP_CART, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0, 0);
    queue_beat(OP_CART, 1'b1, 32'sh80000000, 32'sh80000000, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, 0, 0, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, 32'sh00030000, 32'sh00040000, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, -32'sh00030000, 32'sh00040000, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, -32'sh00030000, -32'sh00040000, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, -32'sh00010000, 0, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b0, 32'sh80000000, 32'sh80000000, 1'b0, 0, 0);
    queue_beat(OP_POLAR, 1'b1, 32'sh12345678, -32'sh00012345, 1'b0, 0, 0);
    queue_beat(OP_ADD, 1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 32'sh00000001, -1);
    queue_beat(OP_ADD, 1'b1, 32'sh00010000, 32'sh00008000, 1'b1, 32'sh00020000,
               -32'sh00020000);
    queue_beat(OP_ADD, 1'b1, 32'sh7FFFFFFF, 0, 1'b1, 32'sh7FFFFFFF, 0);
    queue_beat(OP_ADD, 1'b0, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, 32'sh80000000,
               32'sh0001921F);
    queue_beat(OP_PASS, 1'b1, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, -1, -1);
    queue_beat(OP_PASS, 1'b0, -1, 0, 1'b0, 0, 0);
    drain_pending();

    // Sender holds off until the pipeline has fully emptied.
    hold_sender = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    hold_sender = 1'b0;

    queue_random(300);
    drain_pending();
    send_idle_pct = 54;
    queue_random(300);
    drain_pending();
    send_idle_pct = 0;
    recv_stall_pct = 54;
    queue_random(300);
    drain_pending();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    queue_random(300);
    drain_pending();
    stimulus_done = 1'b1;

    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CORDIC_STEPS + 20) @(posedge clk);

    $display("Run covered %0d input beats and %0d result beats over all four opcodes,",
             beats_in, beats_out);
    $display("with idle, stalled and mixed handshake phases and a full pipeline drain.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("complex_polar_cartesian_unit_core verification clean");
    end else begin
      $display("complex_polar_cartesian_unit_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cpcu_pkg.sv
rtl/core/cpcu_cordic.sv
rtl/core/complex_polar_cartesian_unit_core.sv
tb/tb_complex_polar_cartesian_unit_core.sv
